@@ sv/jht_pkg.sv @@
package jht_pkg;

	localparam int MaxJointsDefault = 256;

	// Multiply sequence: one product per op.
	localparam int NumOps = 56;
	localparam int StepW = 6;

	localparam int AccW = 68;
	localparam int WideW = 48;
	localparam int CompW = 34;
	localparam int MagW = 31;
	localparam int QuotW = 15;
	localparam logic [QuotW-1:0] QuotOne = 15'd16384;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_SQRT = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	typedef enum logic [3:0] {
		A_PW, A_PX, A_PY, A_PZ,
		A_PS0, A_PS1, A_PS2,
		A_M0, A_M1, A_M2, A_M3
	} a_src_t;

	typedef enum logic [4:0] {
		B_LW, B_LX, B_LY, B_LZ,
		B_LS0, B_LS1, B_LS2,
		B_LT0, B_LT1, B_LT2,
		B_V0, B_V1, B_V2,
		B_UV0, B_UV1, B_UV2,
		B_M0, B_M1, B_M2, B_M3
	} b_src_t;

	typedef enum logic [4:0] {
		D_NONE,
		D_C0, D_C1, D_C2, D_C3,
		D_SUM,
		D_SC0, D_SC1, D_SC2,
		D_V0, D_V1, D_V2,
		D_UV0, D_UV1, D_UV2,
		D_UUV0, D_UUV1, D_UUV2,
		D_WUV0, D_WUV1, D_WUV2
	} dst_t;

	typedef struct packed {
		a_src_t a;
		b_src_t b;
		logic   hi;
		logic   neg;
		logic   first;
		dst_t   dst;
	} op_t;

	function automatic op_t mk_op(input a_src_t a, input b_src_t b, input logic hi,
			input logic neg, input logic first, input dst_t dst);
		op_t o;
		o.a = a;
		o.b = b;
		o.hi = hi;
		o.neg = neg;
		o.first = first;
		o.dst = dst;
		return o;
	endfunction

	// Wide operands (v, uv) are split into a low 32-bit word and a high part
	// shifted up by 32, so every product fits the shared multiplier.
	function automatic op_t op_rom(input logic [StepW-1:0] step);
		op_t o;
		case (step)
			6'd0:  o = mk_op(A_PW, B_LW, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd1:  o = mk_op(A_PX, B_LX, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd2:  o = mk_op(A_PY, B_LY, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd3:  o = mk_op(A_PZ, B_LZ, 1'b0, 1'b1, 1'b0, D_C0);
			6'd4:  o = mk_op(A_PW, B_LX, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd5:  o = mk_op(A_PX, B_LW, 1'b0, 1'b0, 1'b0, D_NONE);
			6'd6:  o = mk_op(A_PY, B_LZ, 1'b0, 1'b0, 1'b0, D_NONE);
			6'd7:  o = mk_op(A_PZ, B_LY, 1'b0, 1'b1, 1'b0, D_C1);
			6'd8:  o = mk_op(A_PW, B_LY, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd9:  o = mk_op(A_PX, B_LZ, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd10: o = mk_op(A_PY, B_LW, 1'b0, 1'b0, 1'b0, D_NONE);
			6'd11: o = mk_op(A_PZ, B_LX, 1'b0, 1'b0, 1'b0, D_C2);
			6'd12: o = mk_op(A_PW, B_LZ, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd13: o = mk_op(A_PX, B_LY, 1'b0, 1'b0, 1'b0, D_NONE);
			6'd14: o = mk_op(A_PY, B_LX, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd15: o = mk_op(A_PZ, B_LW, 1'b0, 1'b0, 1'b0, D_C3);
			6'd16: o = mk_op(A_M0, B_M0, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd17: o = mk_op(A_M1, B_M1, 1'b0, 1'b0, 1'b0, D_NONE);
			6'd18: o = mk_op(A_M2, B_M2, 1'b0, 1'b0, 1'b0, D_NONE);
			6'd19: o = mk_op(A_M3, B_M3, 1'b0, 1'b0, 1'b0, D_SUM);
			6'd20: o = mk_op(A_PS0, B_LS0, 1'b0, 1'b0, 1'b1, D_SC0);
			6'd21: o = mk_op(A_PS1, B_LS1, 1'b0, 1'b0, 1'b1, D_SC1);
			6'd22: o = mk_op(A_PS2, B_LS2, 1'b0, 1'b0, 1'b1, D_SC2);
			6'd23: o = mk_op(A_PS0, B_LT0, 1'b0, 1'b0, 1'b1, D_V0);
			6'd24: o = mk_op(A_PS1, B_LT1, 1'b0, 1'b0, 1'b1, D_V1);
			6'd25: o = mk_op(A_PS2, B_LT2, 1'b0, 1'b0, 1'b1, D_V2);
			6'd26: o = mk_op(A_PY, B_V2, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd27: o = mk_op(A_PY, B_V2, 1'b1, 1'b0, 1'b0, D_NONE);
			6'd28: o = mk_op(A_PZ, B_V1, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd29: o = mk_op(A_PZ, B_V1, 1'b1, 1'b1, 1'b0, D_UV0);
			6'd30: o = mk_op(A_PZ, B_V0, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd31: o = mk_op(A_PZ, B_V0, 1'b1, 1'b0, 1'b0, D_NONE);
			6'd32: o = mk_op(A_PX, B_V2, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd33: o = mk_op(A_PX, B_V2, 1'b1, 1'b1, 1'b0, D_UV1);
			6'd34: o = mk_op(A_PX, B_V1, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd35: o = mk_op(A_PX, B_V1, 1'b1, 1'b0, 1'b0, D_NONE);
			6'd36: o = mk_op(A_PY, B_V0, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd37: o = mk_op(A_PY, B_V0, 1'b1, 1'b1, 1'b0, D_UV2);
			6'd38: o = mk_op(A_PY, B_UV2, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd39: o = mk_op(A_PY, B_UV2, 1'b1, 1'b0, 1'b0, D_NONE);
			6'd40: o = mk_op(A_PZ, B_UV1, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd41: o = mk_op(A_PZ, B_UV1, 1'b1, 1'b1, 1'b0, D_UUV0);
			6'd42: o = mk_op(A_PZ, B_UV0, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd43: o = mk_op(A_PZ, B_UV0, 1'b1, 1'b0, 1'b0, D_NONE);
			6'd44: o = mk_op(A_PX, B_UV2, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd45: o = mk_op(A_PX, B_UV2, 1'b1, 1'b1, 1'b0, D_UUV1);
			6'd46: o = mk_op(A_PX, B_UV1, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd47: o = mk_op(A_PX, B_UV1, 1'b1, 1'b0, 1'b0, D_NONE);
			6'd48: o = mk_op(A_PY, B_UV0, 1'b0, 1'b1, 1'b0, D_NONE);
			6'd49: o = mk_op(A_PY, B_UV0, 1'b1, 1'b1, 1'b0, D_UUV2);
			6'd50: o = mk_op(A_PW, B_UV0, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd51: o = mk_op(A_PW, B_UV0, 1'b1, 1'b0, 1'b0, D_WUV0);
			6'd52: o = mk_op(A_PW, B_UV1, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd53: o = mk_op(A_PW, B_UV1, 1'b1, 1'b0, 1'b0, D_WUV1);
			6'd54: o = mk_op(A_PW, B_UV2, 1'b0, 1'b0, 1'b1, D_NONE);
			6'd55: o = mk_op(A_PW, B_UV2, 1'b1, 1'b0, 1'b0, D_WUV2);
			default: o = mk_op(A_PW, B_LW, 1'b0, 1'b0, 1'b1, D_NONE);
		endcase
		return o;
	endfunction

endpackage

@@ sv/joint_hierarchy_transform.sv @@
// Forward kinematics over a skeleton, one joint per input beat. A joint whose parent is
// negative or outside the table passes through unchanged. Any other joint is composed
// with the stored parent on one shared 33x33 multiplier: 56 products (quaternion
// product, sum of squares, scales, scaled offset, the two cross products of the vector
// rotation and the w-scaled first cross product), then a 32-step bit-serial square root
// and a 15-step restoring division for each of the four rotation components; a rotation
// product of zero length becomes identity and skips the division. The input is stalled
// until the result moves into the output register; one finished result may wait there
// while the next joint is taken. The joint tables are memories of MAX_JOINTS entries
// with no reset, so a parent must be sent before any of its children.
module joint_hierarchy_transform
	import jht_pkg::*;
#(
	parameter int MAX_JOINTS = MaxJointsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          joint_index,
	input  logic signed [8:0]   parent_index,
	input  logic signed [15:0]  local_rot_w,
	input  logic signed [15:0]  local_rot_x,
	input  logic signed [15:0]  local_rot_y,
	input  logic signed [15:0]  local_rot_z,
	input  logic [15:0]         local_scale_x,
	input  logic [15:0]         local_scale_y,
	input  logic [15:0]         local_scale_z,
	input  logic signed [31:0]  local_trans_x,
	input  logic signed [31:0]  local_trans_y,
	input  logic signed [31:0]  local_trans_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  world_rot_w,
	output logic signed [15:0]  world_rot_x,
	output logic signed [15:0]  world_rot_y,
	output logic signed [15:0]  world_rot_z,
	output logic [15:0]         world_scale_x,
	output logic [15:0]         world_scale_y,
	output logic [15:0]         world_scale_z,
	output logic signed [31:0]  world_trans_x,
	output logic signed [31:0]  world_trans_y,
	output logic signed [31:0]  world_trans_z
);

	localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam logic [12:0] MaxJ = 13'(MAX_JOINTS);
	localparam int TW = 51;
	localparam logic [4:0] SqrtLast = 5'd31;
	localparam logic [4:0] DivLast = 5'd14;
	localparam logic [StepW-1:0] StepLast = StepW'(NumOps - 1);

	state_t state_q;
	logic              phase_q;
	logic [StepW-1:0]  step_q;
	logic [4:0]        cnt_q;
	logic [1:0]        comp_q;
	logic              out_valid_q;
	logic              root_q;
	logic              slot_ok_q;
	logic [AW-1:0]     slot_q;

	// Input item, parent entry and intermediate results.
	logic signed [15:0]       lrot_q [4];
	logic [15:0]              lscale_q [3];
	logic signed [31:0]       ltrans_q [3];
	logic [63:0]              rot_rd_q;
	logic [47:0]              scale_rd_q;
	logic signed [31:0]       ptrans_q [3];
	logic signed [15:0]       prot [4];
	logic [15:0]              pscale [3];
	logic signed [CompW-1:0]  c_q [4];
	logic [63:0]              sum_q;
	logic [15:0]              sc_q [3];
	logic signed [WideW-1:0]  v_q [3];
	logic signed [WideW-1:0]  uv_q [3];
	logic signed [WideW-1:0]  uuv_q [3];
	logic signed [WideW-1:0]  wuv_q [3];
	logic signed [15:0]       res_rot_q [4];
	logic signed [AccW-1:0]   acc_q;
	logic signed [65:0]       prod_s1;

	logic [62:0]       sq_rem_q;
	logic [62:0]       sq_root_q;
	logic [62:0]       sq_bit_q;
	logic [31:0]       n_q;
	logic [32:0]       dv_rem_q;
	logic [QuotW-1:0]  dv_lo_q;
	logic [QuotW-1:0]  dv_quo_q;

	logic signed [15:0]  out_rot_q [4];
	logic [15:0]         out_scale_q [3];
	logic signed [31:0]  out_trans_q [3];

	logic [63:0] rot_mem [MAX_JOINTS];
	logic [47:0] scale_mem [MAX_JOINTS];
	logic [31:0] offx_mem [MAX_JOINTS];
	logic [31:0] offy_mem [MAX_JOINTS];
	logic [31:0] offz_mem [MAX_JOINTS];

	logic in_take;
	logic par_ok;
	logic fin_go;
	op_t op;
	logic [MagW-1:0] mag [4];
	logic signed [32:0] a_val;
	logic signed [32:0] b_val;
	logic signed [AccW-1:0] term;
	logic signed [AccW-1:0] acc_new;
	logic signed [AccW-1:0] acc_sh8;
	logic signed [AccW-1:0] acc_sh14;
	logic [23:0] sc_raw;
	logic [15:0] sc_sat;
	logic [63:0] sq_trial;
	logic        sq_ge;
	logic [62:0] sq_rem_nx;
	logic [62:0] sq_root_nx;
	logic [31:0] n_cur;
	logic [1:0]  dv_sel;
	logic [46:0] dv_num;
	logic [33:0] dv_rem2;
	logic [33:0] dv_den;
	logic        dv_ge;
	logic [32:0] dv_rem_nx;
	logic [QuotW-1:0] dv_quo_nx;
	logic [QuotW-1:0] dv_clip;
	logic signed [15:0] dv_res;
	logic signed [TW-1:0] tsum [3];
	logic signed [31:0] tsat [3];

	assign in_take = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign par_ok = !parent_index[8] && ({5'd0, parent_index[7:0]} < MaxJ);
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign op = op_rom(step_q);

	assign prot[0] = rot_rd_q[63:48];
	assign prot[1] = rot_rd_q[47:32];
	assign prot[2] = rot_rd_q[31:16];
	assign prot[3] = rot_rd_q[15:0];
	assign pscale[0] = scale_rd_q[47:32];
	assign pscale[1] = scale_rd_q[31:16];
	assign pscale[2] = scale_rd_q[15:0];

	always_comb begin
		logic [CompW-1:0] cabs;
		for (int i = 0; i < 4; i++) begin
			cabs = c_q[i][CompW-1] ? CompW'(-c_q[i]) : CompW'(c_q[i]);
			mag[i] = cabs[MagW+1:2];
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (op.a)
			A_PW: a_val = {{17{prot[0][15]}}, prot[0]};
			A_PX: a_val = {{17{prot[1][15]}}, prot[1]};
			A_PY: a_val = {{17{prot[2][15]}}, prot[2]};
			A_PZ: a_val = {{17{prot[3][15]}}, prot[3]};
			A_PS0: a_val = {17'd0, pscale[0]};
			A_PS1: a_val = {17'd0, pscale[1]};
			A_PS2: a_val = {17'd0, pscale[2]};
			A_M0: a_val = {2'd0, mag[0]};
			A_M1: a_val = {2'd0, mag[1]};
			A_M2: a_val = {2'd0, mag[2]};
			A_M3: a_val = {2'd0, mag[3]};
			default: a_val = '0;
		endcase
	end

	always_comb begin
		case (op.b)
			B_LW: b_val = {{17{lrot_q[0][15]}}, lrot_q[0]};
			B_LX: b_val = {{17{lrot_q[1][15]}}, lrot_q[1]};
			B_LY: b_val = {{17{lrot_q[2][15]}}, lrot_q[2]};
			B_LZ: b_val = {{17{lrot_q[3][15]}}, lrot_q[3]};
			B_LS0: b_val = {17'd0, lscale_q[0]};
			B_LS1: b_val = {17'd0, lscale_q[1]};
			B_LS2: b_val = {17'd0, lscale_q[2]};
			B_LT0: b_val = {ltrans_q[0][31], ltrans_q[0]};
			B_LT1: b_val = {ltrans_q[1][31], ltrans_q[1]};
			B_LT2: b_val = {ltrans_q[2][31], ltrans_q[2]};
			B_V0: b_val = op.hi ? {{17{v_q[0][47]}}, v_q[0][47:32]} : {1'b0, v_q[0][31:0]};
			B_V1: b_val = op.hi ? {{17{v_q[1][47]}}, v_q[1][47:32]} : {1'b0, v_q[1][31:0]};
			B_V2: b_val = op.hi ? {{17{v_q[2][47]}}, v_q[2][47:32]} : {1'b0, v_q[2][31:0]};
			B_UV0: b_val = op.hi ? {{17{uv_q[0][47]}}, uv_q[0][47:32]}
					: {1'b0, uv_q[0][31:0]};
			B_UV1: b_val = op.hi ? {{17{uv_q[1][47]}}, uv_q[1][47:32]}
					: {1'b0, uv_q[1][31:0]};
			B_UV2: b_val = op.hi ? {{17{uv_q[2][47]}}, uv_q[2][47:32]}
					: {1'b0, uv_q[2][31:0]};
			B_M0: b_val = {2'd0, mag[0]};
			B_M1: b_val = {2'd0, mag[1]};
			B_M2: b_val = {2'd0, mag[2]};
			B_M3: b_val = {2'd0, mag[3]};
			default: b_val = '0;
		endcase
	end

	always_comb begin
		logic signed [AccW-1:0] t;
		if (op.hi) begin
			t = {prod_s1[AccW-33:0], 32'd0};
		end else begin
			t = {{(AccW-66){prod_s1[65]}}, prod_s1};
		end
		term = op.neg ? -t : t;
		acc_new = (op.first ? '0 : acc_q) + term;
		acc_sh8 = acc_new >>> 8;
		acc_sh14 = acc_new >>> 14;
		sc_raw = acc_new[31:8];
		sc_sat = (|sc_raw[23:16]) ? 16'hffff : sc_raw[15:0];
	end

	// Bit-serial integer square root, one result bit and two radicand bits per step.
	always_comb begin
		sq_trial = {1'b0, sq_root_q} + {1'b0, sq_bit_q};
		sq_ge = ({1'b0, sq_rem_q} >= sq_trial);
		sq_rem_nx = sq_ge ? (sq_rem_q - sq_trial[62:0]) : sq_rem_q;
		sq_root_nx = sq_ge ? ((sq_root_q >> 1) + sq_bit_q) : (sq_root_q >> 1);
	end

	// Restoring division: (2*mag*16384 + n) / (2*n). The quotient never exceeds 16384,
	// so the top part of the numerator already lies below the divisor. The first
	// component is loaded in the last root step, before the length is registered.
	always_comb begin
		n_cur = (state_q == ST_SQRT) ? sq_root_nx[31:0] : n_q;
		dv_sel = (state_q == ST_DIV) ? comp_q + 2'd1 : 2'd0;
		dv_num = {1'b0, mag[dv_sel], 15'd0} + {15'd0, n_cur};
		dv_rem2 = {dv_rem_q, dv_lo_q[QuotW-1]};
		dv_den = {1'b0, n_q, 1'b0};
		dv_ge = (dv_rem2 >= dv_den);
		dv_rem_nx = dv_ge ? 33'(dv_rem2 - dv_den) : dv_rem2[32:0];
		dv_quo_nx = {dv_quo_q[QuotW-2:0], dv_ge};
		dv_clip = (dv_quo_nx > QuotOne) ? QuotOne : dv_quo_nx;
		dv_res = c_q[comp_q][CompW-1] ? -$signed({1'b0, dv_clip})
				: $signed({1'b0, dv_clip});
	end

	always_comb begin
		logic signed [TW-1:0] rs;
		for (int i = 0; i < 3; i++) begin
			rs = {{(TW-WideW){wuv_q[i][WideW-1]}}, wuv_q[i]}
					+ {{(TW-WideW){uuv_q[i][WideW-1]}}, uuv_q[i]};
			tsum[i] = {{(TW-32){ptrans_q[i][31]}}, ptrans_q[i]}
					+ {{(TW-WideW){v_q[i][WideW-1]}}, v_q[i]}
					+ {rs[TW-2:0], 1'b0};
			if ((&tsum[i][TW-1:31]) || !(|tsum[i][TW-1:31])) begin
				tsat[i] = tsum[i][31:0];
			end else if (tsum[i][TW-1]) begin
				tsat[i] = 32'sh80000000;
			end else begin
				tsat[i] = 32'sh7fffffff;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			step_q <= '0;
			cnt_q <= '0;
			comp_q <= '0;
			out_valid_q <= 1'b0;
			root_q <= 1'b0;
			slot_ok_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						root_q <= !par_ok;
						slot_ok_q <= ({5'd0, joint_index} < MaxJ);
						step_q <= '0;
						phase_q <= 1'b0;
						state_q <= par_ok ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (step_q == StepLast) begin
							cnt_q <= '0;
							state_q <= ST_SQRT;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SqrtLast) begin
						cnt_q <= '0;
						comp_q <= '0;
						state_q <= (sq_root_nx == '0) ? ST_FIN : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DivLast) begin
						cnt_q <= '0;
						comp_q <= comp_q + 1'b1;
						if (comp_q == 2'd3) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			slot_q <= AW'(joint_index);
			lrot_q[0] <= local_rot_w;
			lrot_q[1] <= local_rot_x;
			lrot_q[2] <= local_rot_y;
			lrot_q[3] <= local_rot_z;
			lscale_q[0] <= local_scale_x;
			lscale_q[1] <= local_scale_y;
			lscale_q[2] <= local_scale_z;
			ltrans_q[0] <= local_trans_x;
			ltrans_q[1] <= local_trans_y;
			ltrans_q[2] <= local_trans_z;
		end
		if (state_q == ST_MUL && !phase_q) begin
			prod_s1 <= a_val * b_val;
		end
		if (state_q == ST_MUL && phase_q) begin
			acc_q <= acc_new;
			case (op.dst)
				D_C0: c_q[0] <= acc_new[CompW-1:0];
				D_C1: c_q[1] <= acc_new[CompW-1:0];
				D_C2: c_q[2] <= acc_new[CompW-1:0];
				D_C3: c_q[3] <= acc_new[CompW-1:0];
				D_SUM: sum_q <= acc_new[63:0];
				D_SC0: sc_q[0] <= sc_sat;
				D_SC1: sc_q[1] <= sc_sat;
				D_SC2: sc_q[2] <= sc_sat;
				D_V0: v_q[0] <= acc_sh8[WideW-1:0];
				D_V1: v_q[1] <= acc_sh8[WideW-1:0];
				D_V2: v_q[2] <= acc_sh8[WideW-1:0];
				D_UV0: uv_q[0] <= acc_sh14[WideW-1:0];
				D_UV1: uv_q[1] <= acc_sh14[WideW-1:0];
				D_UV2: uv_q[2] <= acc_sh14[WideW-1:0];
				D_UUV0: uuv_q[0] <= acc_sh14[WideW-1:0];
				D_UUV1: uuv_q[1] <= acc_sh14[WideW-1:0];
				D_UUV2: uuv_q[2] <= acc_sh14[WideW-1:0];
				D_WUV0: wuv_q[0] <= acc_sh14[WideW-1:0];
				D_WUV1: wuv_q[1] <= acc_sh14[WideW-1:0];
				D_WUV2: wuv_q[2] <= acc_sh14[WideW-1:0];
				default: ;
			endcase
			if (step_q == StepLast) begin
				sq_rem_q <= sum_q[62:0];
				sq_root_q <= '0;
				sq_bit_q <= {1'b1, 62'd0};
			end
		end
		if (state_q == ST_SQRT) begin
			sq_rem_q <= sq_rem_nx;
			sq_root_q <= sq_root_nx;
			sq_bit_q <= sq_bit_q >> 2;
			if (cnt_q == SqrtLast) begin
				n_q <= sq_root_nx[31:0];
				res_rot_q[0] <= 16'sd16384;
				res_rot_q[1] <= '0;
				res_rot_q[2] <= '0;
				res_rot_q[3] <= '0;
			end
		end
		// Load the division for the next component, or step the current one.
		if ((state_q == ST_SQRT && cnt_q == SqrtLast)
				|| (state_q == ST_DIV && cnt_q == DivLast)) begin
			dv_rem_q <= {1'b0, dv_num[46:15]};
			dv_lo_q <= dv_num[14:0];
			dv_quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			dv_rem_q <= dv_rem_nx;
			dv_lo_q <= {dv_lo_q[QuotW-2:0], 1'b0};
			dv_quo_q <= dv_quo_nx;
		end
		if (state_q == ST_DIV && cnt_q == DivLast) begin
			res_rot_q[comp_q] <= dv_res;
		end
		if (fin_go) begin
			for (int i = 0; i < 4; i++) begin
				out_rot_q[i] <= root_q ? lrot_q[i] : res_rot_q[i];
			end
			for (int i = 0; i < 3; i++) begin
				out_scale_q[i] <= root_q ? lscale_q[i] : sc_q[i];
				out_trans_q[i] <= root_q ? ltrans_q[i] : tsat[i];
			end
		end
	end

	// Joint tables: the parent is read when the beat is taken, the slot is
	// written when the result leaves, so a joint may name itself as parent.
	always_ff @(posedge clk) begin
		if (in_take) begin
			rot_rd_q <= rot_mem[AW'(parent_index[7:0])];
			scale_rd_q <= scale_mem[AW'(parent_index[7:0])];
			ptrans_q[0] <= offx_mem[AW'(parent_index[7:0])];
			ptrans_q[1] <= offy_mem[AW'(parent_index[7:0])];
			ptrans_q[2] <= offz_mem[AW'(parent_index[7:0])];
		end
		if (fin_go && slot_ok_q) begin
			if (root_q) begin
				rot_mem[slot_q] <= {lrot_q[0], lrot_q[1], lrot_q[2], lrot_q[3]};
				scale_mem[slot_q] <= {lscale_q[0], lscale_q[1], lscale_q[2]};
				offx_mem[slot_q] <= ltrans_q[0];
				offy_mem[slot_q] <= ltrans_q[1];
				offz_mem[slot_q] <= ltrans_q[2];
			end else begin
				rot_mem[slot_q] <= {res_rot_q[0], res_rot_q[1], res_rot_q[2], res_rot_q[3]};
				scale_mem[slot_q] <= {sc_q[0], sc_q[1], sc_q[2]};
				offx_mem[slot_q] <= tsat[0];
				offy_mem[slot_q] <= tsat[1];
				offz_mem[slot_q] <= tsat[2];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign world_rot_w = out_rot_q[0];
	assign world_rot_x = out_rot_q[1];
	assign world_rot_y = out_rot_q[2];
	assign world_rot_z = out_rot_q[3];
	assign world_scale_x = out_scale_q[0];
	assign world_scale_y = out_scale_q[1];
	assign world_scale_z = out_scale_q[2];
	assign world_trans_x = out_trans_q[0];
	assign world_trans_y = out_trans_q[1];
	assign world_trans_z = out_trans_q[2];

`ifndef NO_ASSERTIONS
	a_root_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && !par_ok) |=> (state_q == ST_FIN))
		else $error("root joint did not go straight to the result stage");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (n_q != '0))
		else $error("division started with a zero length");
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == DivLast) |-> (dv_quo_nx <= QuotOne))
		else $error("normalized component exceeds unit length");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (step_q <= StepLast))
		else $error("multiply sequence ran past its last op");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result beat raised outside the result stage");
`endif

endmodule

@@ tb/joint_hierarchy_transform_tb.sv @@
`timescale 1ns / 100ps

module joint_hierarchy_transform_tb;
	import jht_pkg::*;

	localparam int Joints = 256;
	localparam int WatchdogLimit = 6000;
	localparam int TailCycles = 250;

	typedef struct {
		logic signed [15:0] rot[4];
		logic [15:0]        scl[3];
		logic signed [31:0] trn[3];
	} pose_t;

	typedef struct {
		logic [7:0]        joint;
		logic signed [8:0] parent;
		pose_t             pose;
	} joint_beat_t;

	class PoseScoreboard;
		pose_t world_poses[Joints];
		pose_t pending_poses[$];
		int errors = 0;

		function longint unsigned root64(longint unsigned val);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > val)
				b >>= 2;
			while (b != 0) begin
				if (val >= r + b) begin
					val -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function pose_t compose(pose_t par, pose_t loc);
			pose_t res;
			longint pq[4], lq[4], c[4], v[3], uv[3], uuv[3], pos;
			longint unsigned mag[4], sum, n, quo, s;
			for (int i = 0; i < 4; i++) begin
				pq[i] = par.rot[i];
				lq[i] = loc.rot[i];
			end
			c[0] = pq[0]*lq[0] - pq[1]*lq[1] - pq[2]*lq[2] - pq[3]*lq[3];
			c[1] = pq[0]*lq[1] + pq[1]*lq[0] + pq[2]*lq[3] - pq[3]*lq[2];
			c[2] = pq[0]*lq[2] - pq[1]*lq[3] + pq[2]*lq[0] + pq[3]*lq[1];
			c[3] = pq[0]*lq[3] + pq[1]*lq[2] - pq[2]*lq[1] + pq[3]*lq[0];
			sum = 0;
			for (int i = 0; i < 4; i++) begin
				mag[i] = ((c[i] < 0) ? -c[i] : c[i]) >> 2;
				sum += mag[i] * mag[i];
			end
			n = root64(sum);
			// A product of zero length falls back to the identity rotation.
			if (n == 0) begin
				res.rot = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
			end else begin
				for (int i = 0; i < 4; i++) begin
					quo = (2 * mag[i] * 16384 + n) / (2 * n);
					if (quo > 16384)
						quo = 16384;
					res.rot[i] = (c[i] < 0) ? -longint'(quo) : longint'(quo);
				end
			end
			for (int i = 0; i < 3; i++) begin
				s = (longint'(par.scl[i]) * longint'(loc.scl[i])) >> 8;
				res.scl[i] = (s > 65535) ? 16'hffff : s[15:0];
				v[i] = (longint'(par.scl[i]) * longint'(loc.trn[i])) >>> 8;
			end
			uv[0] = (pq[2]*v[2] - pq[3]*v[1]) >>> 14;
			uv[1] = (pq[3]*v[0] - pq[1]*v[2]) >>> 14;
			uv[2] = (pq[1]*v[1] - pq[2]*v[0]) >>> 14;
			uuv[0] = (pq[2]*uv[2] - pq[3]*uv[1]) >>> 14;
			uuv[1] = (pq[3]*uv[0] - pq[1]*uv[2]) >>> 14;
			uuv[2] = (pq[1]*uv[1] - pq[2]*uv[0]) >>> 14;
			for (int i = 0; i < 3; i++) begin
				pos = longint'(par.trn[i]) + v[i] + 2 * (((uv[i] * pq[0]) >>> 14) + uuv[i]);
				if (pos > 64'sd2147483647)
					res.trn[i] = 32'sh7fffffff;
				else if (pos < -64'sd2147483648)
					res.trn[i] = 32'sh80000000;
				else
					res.trn[i] = pos[31:0];
			end
			return res;
		endfunction

		function void note_joint(joint_beat_t b);
			pose_t res;
			// The parent entry is read before the joint's own slot is written.
			if (b.parent < 0)
				res = b.pose;
			else
				res = compose(world_poses[b.parent[7:0]], b.pose);
			world_poses[b.joint] = res;
			pending_poses.push_back(res);
		endfunction

		function void compare(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_pose(pose_t got);
			pose_t want;
			if (pending_poses.size() == 0) begin
				$error("output beat with no joint outstanding");
				errors++;
				return;
			end
			want = pending_poses.pop_front();
			compare("world_rot_w", want.rot[0], got.rot[0]);
			compare("world_rot_x", want.rot[1], got.rot[1]);
			compare("world_rot_y", want.rot[2], got.rot[2]);
			compare("world_rot_z", want.rot[3], got.rot[3]);
			compare("world_scale_x", want.scl[0], got.scl[0]);
			compare("world_scale_y", want.scl[1], got.scl[1]);
			compare("world_scale_z", want.scl[2], got.scl[2]);
			compare("world_trans_x", want.trn[0], got.trn[0]);
			compare("world_trans_y", want.trn[1], got.trn[1]);
			compare("world_trans_z", want.trn[2], got.trn[2]);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] joint_index = '0;
	logic signed [8:0] parent_index = '0;
	logic signed [15:0] local_rot_w = '0, local_rot_x = '0, local_rot_y = '0, local_rot_z = '0;
	logic [15:0] local_scale_x = '0, local_scale_y = '0, local_scale_z = '0;
	logic signed [31:0] local_trans_x = '0, local_trans_y = '0, local_trans_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] world_rot_w, world_rot_x, world_rot_y, world_rot_z;
	logic [15:0] world_scale_x, world_scale_y, world_scale_z;
	logic signed [31:0] world_trans_x, world_trans_y, world_trans_z;

	PoseScoreboard poses = new();
	bit slot_written[Joints];
	int tx_idle_pct = 15;
	int rx_idle_pct = 86;
	int quiet_cycles = 0;

	joint_hierarchy_transform dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		pose_t got;
		if (out_valid && !out_stall) begin
			got.rot = '{world_rot_w, world_rot_x, world_rot_y, world_rot_z};
			got.scl = '{world_scale_x, world_scale_y, world_scale_z};
			got.trn = '{world_trans_x, world_trans_y, world_trans_z};
			poses.check_pose(got);
		end
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("joint_hierarchy_transform regression: fail");
			$finish;
		end
	end

	function automatic joint_beat_t make_beat(int joint, int parent,
			int rw, int rx, int ry, int rz, int sx, int sy, int sz, int tx, int ty, int tz);
		joint_beat_t b;
		b.joint = joint;
		b.parent = parent;
		b.pose.rot = '{rw, rx, ry, rz};
		b.pose.scl = '{sx, sy, sz};
		b.pose.trn = '{tx, ty, tz};
		return b;
	endfunction

	function automatic int rand_rot();
		return int'($urandom_range(32768)) - 16384;
	endfunction

	function automatic int rand_scale();
		case ($urandom_range(9))
			0: return 0;
			1: return 65535;
			2, 3: return $urandom_range(65535);
			default: return $urandom_range(512, 128);
		endcase
	endfunction

	function automatic int rand_trans();
		return ($urandom_range(2) == 0) ? int'($urandom_range(2000000)) - 1000000 : $urandom;
	endfunction

	function automatic joint_beat_t random_beat();
		joint_beat_t b;
		int parent, tries;
		parent = -1;
		if ($urandom_range(3) != 0) begin
			for (tries = 0; tries < 8; tries++) begin
				parent = $urandom_range(Joints - 1);
				if (slot_written[parent])
					break;
				parent = -1;
			end
		end
		if (parent < 0)
			parent = ($urandom_range(3) == 0) ? -int'($urandom_range(256, 1)) : -1;
		b = make_beat($urandom_range(Joints - 1), parent, 0, 0, 0, 0,
			rand_scale(), rand_scale(), rand_scale(), rand_trans(), rand_trans(), rand_trans());
		case ($urandom_range(9))
			0: b.pose.rot = '{0, 0, 0, 0};
			1: b.pose.rot = '{($urandom_range(1) ? 16384 : -16384), 0, 0, 0};
			default: b.pose.rot = '{rand_rot(), rand_rot(), rand_rot(), rand_rot()};
		endcase
		return b;
	endfunction

	task automatic send_joint(joint_beat_t b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		joint_index <= b.joint;
		parent_index <= b.parent;
		local_rot_w <= b.pose.rot[0];
		local_rot_x <= b.pose.rot[1];
		local_rot_y <= b.pose.rot[2];
		local_rot_z <= b.pose.rot[3];
		local_scale_x <= b.pose.scl[0];
		local_scale_y <= b.pose.scl[1];
		local_scale_z <= b.pose.scl[2];
		local_trans_x <= b.pose.trn[0];
		local_trans_y <= b.pose.trn[1];
		local_trans_z <= b.pose.trn[2];
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		poses.note_joint(b);
		slot_written[b.joint] = 1'b1;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (poses.pending_poses.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			send_joint(random_beat());
		drain_results();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Roots at the field extremes, including a rotation of zero length.
		send_joint(make_beat(0, -1, 16384, 0, 0, 0, 256, 256, 256, 0, 0, 0));
		send_joint(make_beat(1, -256, -16384, 16384, -16384, 16384, 65535, 65535, 65535,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_joint(make_beat(2, -1, 0, 0, 0, 0, 0, 0, 0,
			32'h80000000, 32'h80000000, 32'h80000000));
		send_joint(make_beat(255, -1, 11585, 11585, 0, 0, 384, 128, 1024, 65536, -65536, 7));
		// Children: scale and translation saturation, identity fallback, self parent.
		send_joint(make_beat(3, 1, 16384, 0, 0, 0, 65535, 65535, 65535,
			32'h7fffffff, 32'h80000000, 32'h7fffffff));
		send_joint(make_beat(4, 2, 8192, -8192, 8192, -8192, 512, 512, 512,
			32'h80000000, 32'h80000000, 32'h80000000));
		send_joint(make_beat(5, 0, 0, 0, 0, 0, 256, 256, 256, 1, -1, 0));
		send_joint(make_beat(6, 255, -16384, -16384, -16384, -16384, 65535, 0, 256,
			32'h40000000, -12345, 99999));
		send_joint(make_beat(255, 255, 0, 16384, 0, 0, 300, 200, 256, 131072, 262144, -5));
		send_joint(make_beat(7, 6, 1, -1, 1, -1, 1, 2, 3, -1, -2, -3));
		send_joint(make_beat(0, 0, 16384, 0, 0, 0, 256, 256, 256, 0, 0, 0));
		send_joint(make_beat(8, 1, 16384, 16384, 16384, 16384, 256, 256, 256,
			32'h7fffffff, 0, 32'h80000000));
		drain_results();

		random_phase(450);
		tx_idle_pct = 86;
		rx_idle_pct = 15;
		random_phase(450);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(500);

		repeat (TailCycles) @(posedge clk);
		if (poses.errors == 0 && poses.pending_poses.size() == 0)
			$display("joint_hierarchy_transform regression: pass");
		else
			$display("joint_hierarchy_transform regression: fail");
		$finish;
	end

endmodule
